@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a named clock with an active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Assert a property on the standard clock and reset of the block.
`define ASSERT_STD(lbl, prop) `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

@@ sv/sfpeq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpeq_pkg
// Constants, types and helpers shared by the four-band equaliser modules.
// ----------------------------------------------------------------------------
package sfpeq_pkg;

  // Cascade depth and corner state store
  localparam int STAGES            = 1;
  localparam int ENTRIES_PER_STAGE = 6;
  localparam int ENTRIES           = ENTRIES_PER_STAGE * STAGES;
  localparam int AW                = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW                = (STAGES > 1) ? $clog2(STAGES) : 1;

  // Data widths
  localparam int SAMPLE_W = 24;
  localparam int STATE_W  = 32;
  localparam int OP_W     = 35;
  localparam int K_W      = 17;
  localparam int PROD_W   = OP_W + K_W;
  localparam int ACC_W    = 54;
  localparam int REG_W    = 16;

  // Register port
  localparam int NUM_REGS    = 7;
  localparam int NUM_BANDS   = 4;
  localparam int NUM_CORNERS = 3;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int RIDX_W      = PADDR_W - 2;

  // Register indexes
  localparam logic [RIDX_W-1:0] REG_TREBLE_GAIN    = 3'd0;
  localparam logic [RIDX_W-1:0] REG_UPPER_MID_GAIN = 3'd1;
  localparam logic [RIDX_W-1:0] REG_LOWER_MID_GAIN = 3'd2;
  localparam logic [RIDX_W-1:0] REG_BASS_GAIN      = 3'd3;
  localparam logic [RIDX_W-1:0] REG_HIGH_COEF      = 3'd4;
  localparam logic [RIDX_W-1:0] REG_MID_COEF       = 3'd5;
  localparam logic [RIDX_W-1:0] REG_LOW_COEF       = 3'd6;

  // Reset values
  localparam logic [REG_W-1:0] RST_GAIN      = 16'd16384;
  localparam logic [REG_W-1:0] RST_HIGH_COEF = 16'd17050;
  localparam logic [REG_W-1:0] RST_MID_COEF  = 16'd2653;
  localparam logic [REG_W-1:0] RST_LOW_COEF  = 16'd476;

  // Corner, band and channel codes
  localparam logic [1:0] CORNER_HIGH = 2'd0;
  localparam logic [1:0] CORNER_MID  = 2'd1;
  localparam logic [1:0] CORNER_LOW  = 2'd2;

  localparam logic [1:0] BAND_TREBLE    = 2'd0;
  localparam logic [1:0] BAND_UPPER_MID = 2'd1;
  localparam logic [1:0] BAND_LOWER_MID = 2'd2;
  localparam logic [1:0] BAND_BASS      = 2'd3;

  localparam logic CHAN_LEFT  = 1'b0;
  localparam logic CHAN_RIGHT = 1'b1;

  typedef struct packed {
    logic [NUM_BANDS-1:0][REG_W-1:0]   gain;
    logic [NUM_CORNERS-1:0][REG_W-1:0] coef;
  } cfg_t;

  typedef struct packed {
    logic          in_load;
    logic          rd;
    logic          ld;
    logic          ma;
    logic          mb;
    logic          wb;
    logic          band_load;
    logic [1:0]    band_idx;
    logic          acc_en;
    logic          acc_first;
    logic          fin;
    logic          last_stage;
    logic          chan;
    logic [1:0]    corner;
    logic [AW-1:0] addr;
    logic          out_load;
  } dp_cmd_t;

  // Saturate a wide signed value to 32-bit signed
  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic all_ones;
    logic all_zeros;
    all_ones  = &x[ACC_W-1:STATE_W-1];
    all_zeros = ~|x[ACC_W-1:STATE_W-1];
    if (all_ones || all_zeros) begin
      return x[STATE_W-1:0];
    end else if (x[ACC_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ sv/sfpeq_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpeq_regs
// Register file for band gains and corner coefficients behind the APB port.
// ----------------------------------------------------------------------------
module sfpeq_regs import sfpeq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [NUM_BANDS-1:0][REG_W-1:0]   gain_q;
  logic [NUM_CORNERS-1:0][REG_W-1:0] coef_q;
  logic [RIDX_W-1:0]                 idx;
  logic                              wr_en;
  logic [REG_W-1:0]                  rd_val;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q                <= {NUM_BANDS{RST_GAIN}};
      coef_q[CORNER_HIGH]   <= RST_HIGH_COEF;
      coef_q[CORNER_MID]    <= RST_MID_COEF;
      coef_q[CORNER_LOW]    <= RST_LOW_COEF;
    end else if (wr_en) begin
      unique case (idx)
        REG_TREBLE_GAIN:    gain_q[BAND_TREBLE]    <= pwdata[REG_W-1:0];
        REG_UPPER_MID_GAIN: gain_q[BAND_UPPER_MID] <= pwdata[REG_W-1:0];
        REG_LOWER_MID_GAIN: gain_q[BAND_LOWER_MID] <= pwdata[REG_W-1:0];
        REG_BASS_GAIN:      gain_q[BAND_BASS]      <= pwdata[REG_W-1:0];
        REG_HIGH_COEF:      coef_q[CORNER_HIGH]    <= pwdata[REG_W-1:0];
        REG_MID_COEF:       coef_q[CORNER_MID]     <= pwdata[REG_W-1:0];
        REG_LOW_COEF:       coef_q[CORNER_LOW]     <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TREBLE_GAIN:    rd_val = gain_q[BAND_TREBLE];
      REG_UPPER_MID_GAIN: rd_val = gain_q[BAND_UPPER_MID];
      REG_LOWER_MID_GAIN: rd_val = gain_q[BAND_LOWER_MID];
      REG_BASS_GAIN:      rd_val = gain_q[BAND_BASS];
      REG_HIGH_COEF:      rd_val = coef_q[CORNER_HIGH];
      REG_MID_COEF:       rd_val = coef_q[CORNER_MID];
      REG_LOW_COEF:       rd_val = coef_q[CORNER_LOW];
      default:            rd_val = '0;
    endcase
  end

  assign prdata     = {{(PDATA_W-REG_W){1'b0}}, rd_val};
  assign cfg_o.gain = gain_q;
  assign cfg_o.coef = coef_q;

endmodule

@@ sv/sfpeq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpeq_ctrl
// Sequencer: walks channels, stages, corners and bands, drives the datapath.
// ----------------------------------------------------------------------------
module sfpeq_ctrl import sfpeq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RD   = 9'b000000010,
    ST_LD   = 9'b000000100,
    ST_MA   = 9'b000001000,
    ST_MB   = 9'b000010000,
    ST_WB   = 9'b000100000,
    ST_BAND = 9'b001000000,
    ST_FIN  = 9'b010000000,
    ST_DONE = 9'b100000000
  } ctrl_state_e;

  // Products are registered behind the operand registers, so accumulate with a lag
  localparam logic [2:0] ACC_LAG   = 3'd2;
  localparam logic [2:0] BAND_LAST = 3'(NUM_BANDS + 1);
  localparam logic [2:0] BAND_END  = 3'(NUM_BANDS);

  ctrl_state_e   state_q, state_d;
  logic [SW-1:0] stage_q, stage_d;
  logic [1:0]    corner_q, corner_d;
  logic          ch_q, ch_d;
  logic [2:0]    band_q, band_d;
  logic          out_valid_q, out_valid_d;
  logic          last_stage;

  assign last_stage = (stage_q == SW'(STAGES - 1));

  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    corner_d    = corner_q;
    ch_d        = ch_q;
    band_d      = band_q;

    cmd_o            = '0;
    cmd_o.addr       = AW'(stage_q) * AW'(ENTRIES_PER_STAGE) + AW'({corner_q, ch_q});
    cmd_o.corner     = corner_q;
    cmd_o.chan       = ch_q;
    cmd_o.last_stage = last_stage;
    cmd_o.band_idx   = band_q[1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          stage_d       = '0;
          corner_d      = CORNER_HIGH;
          ch_d          = CHAN_LEFT;
          state_d       = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_LD;
      end
      ST_LD: begin
        cmd_o.ld = 1'b1;
        state_d  = ST_MA;
      end
      ST_MA: begin
        cmd_o.ma = 1'b1;
        state_d  = ST_MB;
      end
      ST_MB: begin
        cmd_o.mb = 1'b1;
        state_d  = ST_WB;
      end
      ST_WB: begin
        cmd_o.wb = 1'b1;
        if (corner_q == CORNER_LOW) begin
          band_d  = '0;
          state_d = ST_BAND;
        end else begin
          corner_d = corner_q + 2'd1;
          state_d  = ST_RD;
        end
      end
      ST_BAND: begin
        cmd_o.band_load = (band_q < BAND_END);
        cmd_o.acc_en    = (band_q >= ACC_LAG);
        cmd_o.acc_first = (band_q == ACC_LAG);
        if (band_q == BAND_LAST) begin
          state_d = ST_FIN;
        end else begin
          band_d = band_q + 3'd1;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        corner_d  = CORNER_HIGH;
        if (!last_stage) begin
          stage_d = stage_q + SW'(1);
          state_d = ST_RD;
        end else if (ch_q == CHAN_LEFT) begin
          ch_d    = CHAN_RIGHT;
          stage_d = '0;
          state_d = ST_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= '0;
      corner_q    <= CORNER_HIGH;
      ch_q        <= CHAN_LEFT;
      band_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      corner_q    <= corner_d;
      ch_q        <= ch_d;
      band_q      <= band_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ sv/sfpeq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpeq_dp
// Datapath: corner state memory, shared multiplier, accumulator, result regs.
// ----------------------------------------------------------------------------
module sfpeq_dp import sfpeq_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  input  cfg_t                       cfg_i,
  input  logic signed [SAMPLE_W-1:0] left_sample_i,
  input  logic signed [SAMPLE_W-1:0] right_sample_i,
  output logic signed [SAMPLE_W-1:0] left_out_o,
  output logic signed [SAMPLE_W-1:0] right_out_o,
  output logic                       clipped_o
);

  localparam int SLEW_SHIFT = 17;
  localparam int VAL_SHIFT  = 16;
  localparam int GAIN_SHIFT = 14;
  localparam logic signed [ACC_W-1:0] SLEW_RND  = ACC_W'(65536);
  localparam logic signed [ACC_W-1:0] VAL_RND   = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] STAGE_RND = ACC_W'(8192);

  // Clamp to the output range; top bit flags a clip
  function automatic logic [SAMPLE_W:0] clamp24(input logic signed [STATE_W-1:0] x);
    logic fits;
    fits = (&x[STATE_W-1:SAMPLE_W-1]) || (~|x[STATE_W-1:SAMPLE_W-1]);
    if (fits) begin
      return {1'b0, x[SAMPLE_W-1:0]};
    end else if (x[STATE_W-1]) begin
      return {1'b1, 1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

  logic signed [SAMPLE_W-1:0] right_q;
  logic signed [STATE_W-1:0]  x_q, res_l_q, res_r_q, slew_q;
  logic signed [STATE_W-1:0]  cout_q [NUM_CORNERS];
  logic signed [STATE_W:0]    vw_q;
  logic signed [OP_W-1:0]     op_q;
  logic signed [K_W-1:0]      k_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;

  logic [2*STATE_W-1:0] mem_q [ENTRIES];
  logic [2*STATE_W-1:0] rd_q;
  logic [ENTRIES-1:0]   vld_q;
  logic                 rvld_q;

  logic signed [STATE_W-1:0] s, v, w, val, slew, y;
  logic signed [STATE_W:0]   band;
  logic signed [ACC_W-1:0]   slew_full, val_full, stage_full;
  logic [SAMPLE_W:0]         cl_l, cl_r;

  // Corner input: stage input for the high corner, previous corner otherwise
  always_comb begin
    case (cmd_i.corner)
      CORNER_HIGH: s = x_q;
      CORNER_MID:  s = cout_q[CORNER_HIGH];
      CORNER_LOW:  s = cout_q[CORNER_MID];
      default:     s = x_q;
    endcase
  end

  // Unwritten entries read as zero
  assign v = rvld_q ? signed'(rd_q[STATE_W-1:0])         : '0;
  assign w = rvld_q ? signed'(rd_q[2*STATE_W-1:STATE_W]) : '0;

  always_comb begin
    case (cmd_i.band_idx)
      BAND_TREBLE:    band = (STATE_W+1)'(x_q) - (STATE_W+1)'(cout_q[CORNER_HIGH]);
      BAND_UPPER_MID: band = (STATE_W+1)'(cout_q[CORNER_HIGH])
                             - (STATE_W+1)'(cout_q[CORNER_MID]);
      BAND_LOWER_MID: band = (STATE_W+1)'(cout_q[CORNER_MID])
                             - (STATE_W+1)'(cout_q[CORNER_LOW]);
      default:        band = (STATE_W+1)'(cout_q[CORNER_LOW]);
    endcase
  end

  assign slew_full  = (ACC_W'(prod_q) + SLEW_RND) >>> SLEW_SHIFT;
  assign val_full   = ((ACC_W'(vw_q) <<< VAL_SHIFT) + ACC_W'(prod_q) + VAL_RND) >>> VAL_SHIFT;
  assign stage_full = (acc_q + STAGE_RND) >>> GAIN_SHIFT;
  assign slew       = sat32(slew_full);
  assign val        = sat32(val_full);
  assign y          = sat32(stage_full);
  assign cl_l       = clamp24(res_l_q);
  assign cl_r       = clamp24(res_r_q);

  // Corner state memory, value in the low half and slew in the high half
  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      mem_q[cmd_i.addr] <= {slew_q, val};
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.wb) begin
        vld_q[cmd_i.addr] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rvld_q <= vld_q[cmd_i.addr];
      end
    end
  end

  // Shared multiplier, registered every cycle
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_q) * PROD_W'(k_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      x_q     <= STATE_W'(left_sample_i);
      right_q <= right_sample_i;
    end
    if (cmd_i.ld) begin
      vw_q <= (STATE_W+1)'(v) + (STATE_W+1)'(w);
      op_q <= OP_W'(s) - OP_W'(v) + OP_W'(w);
      k_q  <= signed'({1'b0, cfg_i.coef[cmd_i.corner]});
    end
    if (cmd_i.ma) begin
      op_q <= OP_W'(s) - OP_W'(vw_q);
    end
    if (cmd_i.mb) begin
      slew_q <= slew;
    end
    if (cmd_i.wb) begin
      cout_q[cmd_i.corner] <= val;
    end
    if (cmd_i.band_load) begin
      op_q <= OP_W'(band);
      k_q  <= signed'({1'b0, cfg_i.gain[cmd_i.band_idx]});
    end
    if (cmd_i.acc_en) begin
      acc_q <= cmd_i.acc_first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.fin) begin
      if (!cmd_i.last_stage) begin
        x_q <= y;
      end else if (cmd_i.chan == CHAN_LEFT) begin
        res_l_q <= y;
        x_q     <= STATE_W'(right_q);
      end else begin
        res_r_q <= y;
      end
    end
    if (cmd_i.out_load) begin
      left_out_o  <= cl_l[SAMPLE_W-1:0];
      right_out_o <= cl_r[SAMPLE_W-1:0];
      clipped_o   <= cl_l[SAMPLE_W] | cl_r[SAMPLE_W];
    end
  end

endmodule

@@ sv/stereo_four_band_pear_eq_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_four_band_pear_eq_top
// Stereo four-band equaliser built from cascaded slew-compensated one-pole
// corners, with APB-style configuration of band gains and corner coefficients.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                      | Transaction
//  ---------+----------------------------------------------+----------------------
//  input    | in_valid_i/in_ready_o, left/right_sample_i   | one stereo sample pair
//  output   | out_valid_o/out_ready_i, left/right_out_o,   | one equalised pair
//           | clipped_o                                    |
//  config   | psel, penable, pwrite, paddr, pwdata, prdata | one register write/read
//
//  Sequencing: each corner steps through read, load, two products and write back
//  around the shared multiplier and the corner state memory port; the four band
//  products then stream through the same multiplier.
//  Reset: asynchronous, active low; clears the sequencer, the output valid and
//  the state-memory valid bits and returns the configuration registers to their
//  reset values, so every corner starts from zero with no clearing pass.
//  Stalls: a finished result waits in the output register while the next
//  transaction is accepted; the sequencer only holds when a new result is
//  ready and the previous one has still not been taken.
//
module stereo_four_band_pear_eq_top import sfpeq_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample input
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] left_sample_i,
  input  logic signed [SAMPLE_W-1:0] right_sample_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] left_out_o,
  output logic signed [SAMPLE_W-1:0] right_out_o,
  output logic                       clipped_o,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  // Gains/coefs, to be written only while no transaction is in flight; unenforced
  sfpeq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: accept one pair, walk left then right through every stage
  sfpeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Arithmetic, corner state and the output register
  sfpeq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .clipped_o      (clipped_o)
  );

endmodule

@@ sv/sfpeq_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpeq_chk
// Port-level checks for the equaliser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfpeq_chk import sfpeq_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [SAMPLE_W-1:0] left_out_o,
  input logic signed [SAMPLE_W-1:0] right_out_o,
  input logic                       clipped_o
);

  localparam logic [SAMPLE_W-1:0] RAIL_HI = 24'h7fffff;
  localparam logic [SAMPLE_W-1:0] RAIL_LO = 24'h800000;

  logic out_stall;
  logic left_on_rail;
  logic right_on_rail;

  assign out_stall     = out_valid_o && !out_ready_i;
  assign left_on_rail  = (left_out_o == RAIL_HI) || (left_out_o == RAIL_LO);
  assign right_on_rail = (right_out_o == RAIL_HI) || (right_out_o == RAIL_LO);

  // One transaction in flight: drop ready straight after an accept
  `ASSERT_STD(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o)

  // A fresh result is posted as the sequencer returns to idle
  `ASSERT_STD(a_result_frees_input, $rose(out_valid_o) |-> in_ready_o)

  // A stalled result holds valid and payload
  `ASSERT_STD(a_out_hold_valid, out_stall |=> out_valid_o)
  `ASSERT_STD(a_out_hold_data, out_stall |=> $stable({left_out_o, right_out_o, clipped_o}))

  // A clip leaves at least one channel on a rail
  `ASSERT_STD(a_clip_on_rail, (out_valid_o && clipped_o) |-> (left_on_rail || right_on_rail))

endmodule

bind stereo_four_band_pear_eq_top sfpeq_chk u_sfpeq_chk (.*);

@@ test/tb_stereo_four_band_pear_eq_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_four_band_pear_eq_top
// Self-checking bench for the stereo four-band equaliser. Drives sample pairs
// through a valid/ready channel with random gaps and output stalls, rewrites
// the gain and corner registers over the APB-style port between phases, and
// compares every result against a bit-exact predictor of the filter cascade.
// ----------------------------------------------------------------------------
module tb_stereo_four_band_pear_eq_top;
  import sfpeq_pkg::*;

  // Watchdog: about 1100 transactions with random gaps and stalls, well padded
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 135;
  // Register slot past the last real register; writes there must be dropped
  localparam logic [RIDX_W-1:0] REG_SPARE = 3'd7;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  // Shapes of random stimulus runs
  typedef enum int {WAVE_NOISE, WAVE_LEVEL, WAVE_SQUARE, WAVE_QUIET} wave_e;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left_smp;
    logic signed [SAMPLE_W-1:0] right_smp;
    logic                       clip;
  } eq_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own register bank and corner state, predicts each
  // equalised pair on acceptance and checks results in order.
  // --------------------------------------------------------------------------
  class eq_scoreboard;
    bit [REG_W-1:0] bank [NUM_REGS];
    int             corner_val [ENTRIES];
    int             corner_slew [ENTRIES];
    eq_result_t     pending_pairs[$];
    int             errors;

    function new();
      bank[REG_TREBLE_GAIN]    = RST_GAIN;
      bank[REG_UPPER_MID_GAIN] = RST_GAIN;
      bank[REG_LOWER_MID_GAIN] = RST_GAIN;
      bank[REG_BASS_GAIN]      = RST_GAIN;
      bank[REG_HIGH_COEF]      = RST_HIGH_COEF;
      bank[REG_MID_COEF]       = RST_MID_COEF;
      bank[REG_LOW_COEF]       = RST_LOW_COEF;
      foreach (corner_val[i]) begin
        corner_val[i]  = 0;
        corner_slew[i] = 0;
      end
      errors = 0;
    endfunction

    function void write_reg(int idx, bit [PDATA_W-1:0] data);
      if (idx < NUM_REGS) begin
        bank[idx] = data[REG_W-1:0];
      end
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function longint sat_state(longint x);
      return clamp(x, -64'sd2147483648, 64'sd2147483647);
    endfunction

    // One slew-compensated one-pole corner; returns the new filter value
    function longint run_corner(int idx, longint s, longint f);
      longint v;
      longint w;
      longint nv;
      longint nw;
      v  = corner_val[idx];
      w  = corner_slew[idx];
      nw = ((s - v + w) * f + 65536) >>> 17;
      nv = sat_state((f * s + (65536 - f) * (v + w) + 32768) >>> 16);
      corner_val[idx]  = int'(nv);
      corner_slew[idx] = int'(sat_state(nw));
      return nv;
    endfunction

    function longint equalise_channel(int ch, longint x);
      longint hi;
      longint md;
      longint lo;
      longint acc;
      int     base;
      for (int st = 0; st < STAGES; st++) begin
        base = st * ENTRIES_PER_STAGE + ch;
        hi   = run_corner(base,     x,  longint'(bank[REG_HIGH_COEF]));
        md   = run_corner(base + 2, hi, longint'(bank[REG_MID_COEF]));
        lo   = run_corner(base + 4, md, longint'(bank[REG_LOW_COEF]));
        acc  = (x - hi)  * longint'(bank[REG_TREBLE_GAIN])
             + (hi - md) * longint'(bank[REG_UPPER_MID_GAIN])
             + (md - lo) * longint'(bank[REG_LOWER_MID_GAIN])
             + lo        * longint'(bank[REG_BASS_GAIN]);
        x    = sat_state((acc + 8192) >>> 14);
      end
      return x;
    endfunction

    function void note_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      eq_result_t e;
      longint     lw;
      longint     rw;
      longint     lc;
      longint     rc;
      lw = equalise_channel(CHAN_LEFT, longint'(l));
      rw = equalise_channel(CHAN_RIGHT, longint'(r));
      lc = clamp(lw, -64'sd8388608, 64'sd8388607);
      rc = clamp(rw, -64'sd8388608, 64'sd8388607);
      e.left_smp  = lc[SAMPLE_W-1:0];
      e.right_smp = rc[SAMPLE_W-1:0];
      e.clip      = (lc != lw) || (rc != rw);
      pending_pairs.push_back(e);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                               logic clip);
      eq_result_t e;
      if (pending_pairs.size() == 0) begin
        $display("%0t: result with none pending: left %0d right %0d clipped %0b",
                 $time, l, r, clip);
        errors++;
        return;
      end
      e = pending_pairs.pop_front();
      if (l !== e.left_smp) begin
        $display("%0t: left_out expected %0d actual %0d", $time, e.left_smp, l);
        errors++;
      end
      if (r !== e.right_smp) begin
        $display("%0t: right_out expected %0d actual %0d", $time, e.right_smp, r);
        errors++;
      end
      if (clip !== e.clip) begin
        $display("%0t: clipped expected %0b actual %0b", $time, e.clip, clip);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] left_sample_i  = '0;
  logic signed [SAMPLE_W-1:0] right_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b1;
  logic signed [SAMPLE_W-1:0] left_out_o;
  logic signed [SAMPLE_W-1:0] right_out_o;
  logic                       clipped_o;
  logic                       psel           = 1'b0;
  logic                       penable        = 1'b0;
  logic                       pwrite         = 1'b0;
  logic [PADDR_W-1:0]         paddr          = '0;
  logic [PDATA_W-1:0]         pwdata         = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  eq_scoreboard sb;
  bit           src_steady;   // sender runs back to back while set
  bit           sink_steady;  // receiver never stalls while set
  int           sink_hold;
  int unsigned  cycles = 0;

  stereo_four_band_pear_eq_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .clipped_o      (clipped_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: give up if the run hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("stereo_four_band_pear_eq_top verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: check each output transaction, then stall ready for a random
  // number of cycles (none while sink_steady is set).
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    int stall;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(left_out_o, right_out_o, clipped_o);
        if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
        stall = sink_steady ? 0 : $urandom_range(0, 7);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          sink_hold   <= stall - 1;
        end
      end else if (!out_ready_i) begin
        // count the stall down; raise ready once it expires
        if (sink_hold == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          sink_hold <= sink_hold - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one sample pair after a random gap; note it when the transaction lands
  task automatic push_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
    int gap;
    if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    left_sample_i  <= l;
    right_sample_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pair(l, r);
  endtask

  // Drop valid and hold until every predicted pair has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending_pairs.size() != 0) @(posedge clk_i);
  endtask

  // Two-phase register write: setup, then access until pready
  task automatic apb_write(logic [RIDX_W-1:0] idx, logic [REG_W-1:0] val);
    logic [PDATA_W-1:0] data;
    data = {16'($urandom), val};
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(int'(idx), data);
  endtask

  // Reprogram the whole bank with the block idle
  task automatic program_bank(logic [REG_W-1:0] g_tr, logic [REG_W-1:0] g_um,
                              logic [REG_W-1:0] g_lm, logic [REG_W-1:0] g_bs,
                              logic [REG_W-1:0] c_hi, logic [REG_W-1:0] c_md,
                              logic [REG_W-1:0] c_lo);
    drain_results();
    repeat (4) @(posedge clk_i);
    apb_write(REG_TREBLE_GAIN,    g_tr);
    apb_write(REG_UPPER_MID_GAIN, g_um);
    apb_write(REG_LOWER_MID_GAIN, g_lm);
    apb_write(REG_BASS_GAIN,      g_bs);
    apb_write(REG_HIGH_COEF,      c_hi);
    apb_write(REG_MID_COEF,       c_md);
    apb_write(REG_LOW_COEF,       c_lo);
  endtask

  // Random runs of 16 transactions, each with its own shape: white noise,
  // held levels (lets the slow corners settle), full-swing squares, or
  // quiet signals near zero. Drain once midway to empty the pipe.
  task automatic run_random(int count);
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    logic signed [SAMPLE_W-1:0] lvl_l;
    logic signed [SAMPLE_W-1:0] lvl_r;
    wave_e                      wave;
    wave = WAVE_NOISE;
    lvl_l = '0;
    lvl_r = '0;
    for (int n = 0; n < count; n++) begin
      if (n % 16 == 0) begin
        wave  = wave_e'($urandom_range(0, 3));
        lvl_l = SAMPLE_W'($urandom);
        lvl_r = SAMPLE_W'($urandom);
      end
      case (wave)
        WAVE_NOISE: begin
          l = SAMPLE_W'($urandom);
          r = SAMPLE_W'($urandom);
        end
        WAVE_LEVEL: begin
          l = lvl_l;
          r = lvl_r;
        end
        WAVE_SQUARE: begin
          l = (n % 16 < 8) ? SAMPLE_MAX : SAMPLE_MIN;
          r = (n % 4 < 2) ? SAMPLE_MIN : SAMPLE_MAX;
        end
        default: begin
          l = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
          r = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
        end
      endcase
      push_pair(l, r);
      if (n == count / 2) drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb          = new();
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    sink_hold   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: field extremes and bit patterns
    push_pair('0, '0);
    push_pair(SAMPLE_MAX, SAMPLE_MAX);
    push_pair(SAMPLE_MIN, SAMPLE_MIN);
    push_pair(SAMPLE_MAX, SAMPLE_MIN);
    push_pair(SAMPLE_MIN, SAMPLE_MAX);
    push_pair(-24'sd1, 24'sd1);
    push_pair(24'sh555555, 24'shAAAAAA);
    push_pair(24'shAAAAAA, 24'sh555555);
    push_pair(24'sd1, -24'sd1);
    push_pair('0, '0);

    // Maximum gains and pass-through corners: drive the output into clipping
    program_bank(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_pair(SAMPLE_MAX, SAMPLE_MAX);
    push_pair(SAMPLE_MAX, SAMPLE_MIN);
    push_pair(SAMPLE_MIN, SAMPLE_MIN);
    push_pair(SAMPLE_MIN, SAMPLE_MAX);
    push_pair(24'sh200000, -24'sh200000);
    push_pair(24'sd100, -24'sd100);
    run_random(PHASE_ITEMS);

    // Zero coefficients: every corner holds value plus slew; spare slot write
    program_bank(RST_GAIN, RST_GAIN, RST_GAIN, RST_GAIN, '0, '0, '0);
    apb_write(REG_SPARE, 16'($urandom));
    run_random(PHASE_ITEMS);

    // All gains zero, random corners
    program_bank('0, '0, '0, '0, 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(PHASE_ITEMS);

    program_bank(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(PHASE_ITEMS);

    // Mixed corner extremes with random gains
    program_bank(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'hFFFF, 16'd1, '0);
    run_random(PHASE_ITEMS);

    program_bank(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(PHASE_ITEMS);

    // Treble only at full weight, slow corners
    program_bank(16'hFFFF, '0, '0, '0, 16'd1, 16'd1, 16'd1);
    run_random(PHASE_ITEMS);

    // Back to reset values
    program_bank(RST_GAIN, RST_GAIN, RST_GAIN, RST_GAIN,
                 RST_HIGH_COEF, RST_MID_COEF, RST_LOW_COEF);
    run_random(PHASE_ITEMS);

    // Wait for the tail, then allow a margin for stray results
    drain_results();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_pairs.size() == 0) begin
      $display("stereo_four_band_pear_eq_top verification clean");
    end else begin
      $display("stereo_four_band_pear_eq_top verification failed");
    end
    $finish;
  end

endmodule
